// ===== rtl/csp_pkg.sv =====
// Shared widths, reset values, register codes and controller/datapath types
// for the charge slab profile integrator. No dependencies.
package csp_pkg;

    localparam int MAX_BINS   = 1024;
    localparam int BIN_W      = $clog2(MAX_BINS);
    localparam int ZPOS_W     = 24;
    localparam int CHG_W      = 21;
    localparam int ZLIM_W     = 24;
    localparam int IBW_W      = 32;
    localparam int NB_W       = 11;
    localparam int IA_W       = 24;
    localparam int BSUM_W     = 32;
    localparam int RSUM_W     = 42;
    localparam int FV_W       = 48;
    localparam int MAG_LO_W   = 21;
    localparam int MAG_HI_W   = RSUM_W - MAG_LO_W;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [ZLIM_W-1:0] RST_Z_MIN         = 24'd1310720;
    localparam logic [ZLIM_W-1:0] RST_Z_MAX         = 24'd1966080;
    localparam logic [IBW_W-1:0]  RST_INV_BIN_WIDTH = 32'd6553600;
    localparam logic [NB_W-1:0]   RST_NUM_BINS      = 11'd1000;
    localparam logic [IA_W-1:0]   RST_INV_AREA      = 24'd65536;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_Z_MIN         = 3'd0,
        CFG_Z_MAX         = 3'd1,
        CFG_INV_BIN_WIDTH = 3'd2,
        CFG_NUM_BINS      = 3'd3,
        CFG_INV_AREA      = 3'd4
    } t_cfg_idx;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_CLR,
        OP_LOAD,
        OP_RLOAD,
        OP_AMUL,
        OP_ARD,
        OP_AWR,
        OP_RRD,
        OP_RACC,
        OP_RNEG,
        OP_RMLO,
        OP_RMHI,
        OP_ROUT
    } t_op;

    typedef struct packed {
        t_op op;
    } t_dp_cmd;

    typedef struct packed {
        logic clr_done;
    } t_dp_sts;

endpackage

// ===== rtl/csp_ctrl.sv =====
// Sequencer for the slab integrator: clearing pass, atom binning and bin readout.
// Depends on csp_pkg; drives csp_dpath through t_dp_cmd and reads t_dp_sts.
module csp_ctrl import csp_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_start,
    input  logic    i_func,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd,
    output logic    o_busy
);

    typedef enum logic [3:0] {
        S_CLR,
        S_IDLE,
        S_AMUL,
        S_ARD,
        S_AWR,
        S_RRD,
        S_RACC,
        S_RNEG,
        S_RMLO,
        S_RMHI,
        S_ROUT
    } t_state;

    t_state r_state, n_state;
    logic   r_busy, n_busy;

    always_comb begin
        n_state  = r_state;
        o_cmd.op = OP_NONE;
        case (r_state)
            S_CLR: begin
                o_cmd.op = OP_CLR;
                if (i_sts.clr_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    if (i_func) begin
                        o_cmd.op = OP_RLOAD;
                        n_state  = S_RRD;
                    end else begin
                        o_cmd.op = OP_LOAD;
                        n_state  = S_AMUL;
                    end
                end
            end
            S_AMUL: begin
                o_cmd.op = OP_AMUL;
                n_state  = S_ARD;
            end
            S_ARD: begin
                o_cmd.op = OP_ARD;
                n_state  = S_AWR;
            end
            S_AWR: begin
                o_cmd.op = OP_AWR;
                n_state  = S_IDLE;
            end
            S_RRD: begin
                o_cmd.op = OP_RRD;
                n_state  = S_RACC;
            end
            S_RACC: begin
                o_cmd.op = OP_RACC;
                n_state  = S_RNEG;
            end
            S_RNEG: begin
                o_cmd.op = OP_RNEG;
                n_state  = S_RMLO;
            end
            S_RMLO: begin
                o_cmd.op = OP_RMLO;
                n_state  = S_RMHI;
            end
            S_RMHI: begin
                o_cmd.op = OP_RMHI;
                n_state  = S_ROUT;
            end
            S_ROUT: begin
                o_cmd.op = OP_ROUT;
                n_state  = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        n_busy = (n_state != S_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_busy  <= 1'b1;
        end else begin
            r_state <= n_state;
            r_busy  <= n_busy;
        end
    end

    assign o_busy = r_busy;

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !r_busy) |=> r_busy)
        else $error("busy not raised after accepted beat");

    a_clear_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLR && i_sts.clr_done) |=> !r_busy)
        else $error("busy held after clearing pass");

endmodule

// ===== rtl/csp_dpath.sv =====
// Datapath for the slab integrator: config registers, bin memory, bin index
// multiply, running sum and field scaling. Depends on csp_pkg.
module csp_dpath import csp_pkg::*; (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  t_dp_cmd                       i_cmd,
    output t_dp_sts                       o_sts,
    input  logic                          i_cfg_we,
    input  logic [CFG_IDX_W-1:0]          i_cfg_index,
    input  logic [CFG_DATA_W-1:0]         i_cfg_data,
    input  logic [ZPOS_W-1:0]             i_z_pos,
    input  logic signed [CHG_W-1:0]       i_charge,
    output logic                          o_valid,
    output logic [BIN_W-1:0]              o_bin_index,
    output logic signed [FV_W-1:0]        o_field_value,
    output logic                          o_last_bin
);

    localparam int QW = 66 - 8;
    localparam logic [QW-1:0] FV_POS_LIM = (QW'(1) << (FV_W - 1)) - QW'(1);
    localparam logic [QW-1:0] FV_NEG_LIM = QW'(1) << (FV_W - 1);

    logic [ZLIM_W-1:0]  r_z_min, r_z_max;
    logic [IBW_W-1:0]   r_ibw;
    logic [NB_W-1:0]    r_num_bins;
    logic [IA_W-1:0]    r_ia;

    logic [BSUM_W-1:0]  mem [MAX_BINS];
    logic [BSUM_W-1:0]  r_rdata;
    logic               mem_we;
    logic [BIN_W-1:0]   mem_waddr, mem_raddr;
    logic [BSUM_W-1:0]  mem_wdata;

    logic [BIN_W-1:0]   r_clr_addr;
    logic [BIN_W-1:0]   r_rptr;
    logic [BIN_W-1:0]   r_p;
    logic [RSUM_W-1:0]  r_run;

    logic               r_in_range, r_atom_ok;
    logic [ZPOS_W-1:0]  r_diff;
    logic [CHG_W-1:0]   r_q;
    logic [ZPOS_W-1:0]  r_idx;
    logic [RSUM_W-1:0]  r_sum;
    logic               r_last, r_neg;
    logic [RSUM_W-1:0]  r_mag;
    logic [MAG_LO_W+IA_W-1:0] r_plo;
    logic [MAG_HI_W+IA_W-1:0] r_phi;

    logic               r_valid;
    logic [BIN_W-1:0]   r_out_idx;
    logic [FV_W-1:0]    r_out_fv;
    logic               r_out_last;

    logic [NB_W-1:0]    n_eff;
    logic               rptr_wrap, last;
    logic [ZPOS_W+IBW_W-1:0] idx_prod;
    logic [BSUM_W:0]    bsum_x;
    logic [BSUM_W-1:0]  bsum_sat;
    logic [RSUM_W:0]    rsum_x;
    logic [RSUM_W-1:0]  rsum_sat;
    logic [65:0]        total, rounded;
    logic [QW-1:0]      q, q_sat;
    logic [FV_W-1:0]    fv;

    always_comb begin
        if (r_num_bins == '0) begin
            n_eff = NB_W'(1);
        end else if (r_num_bins > NB_W'(MAX_BINS)) begin
            n_eff = NB_W'(MAX_BINS);
        end else begin
            n_eff = r_num_bins;
        end
    end

    assign rptr_wrap = ({1'b0, r_rptr} >= n_eff);
    assign last      = ({1'b0, r_p} == (n_eff - NB_W'(1)));
    assign idx_prod  = r_diff * r_ibw;

    always_comb begin
        bsum_x = {r_rdata[BSUM_W-1], r_rdata}
               + {{(BSUM_W+1-CHG_W){r_q[CHG_W-1]}}, r_q};
        if (bsum_x[BSUM_W] != bsum_x[BSUM_W-1]) begin
            bsum_sat = bsum_x[BSUM_W] ? {1'b1, {(BSUM_W-1){1'b0}}}
                                      : {1'b0, {(BSUM_W-1){1'b1}}};
        end else begin
            bsum_sat = bsum_x[BSUM_W-1:0];
        end

        rsum_x = {r_run[RSUM_W-1], r_run}
               + {{(RSUM_W+1-BSUM_W){r_rdata[BSUM_W-1]}}, r_rdata};
        if (rsum_x[RSUM_W] != rsum_x[RSUM_W-1]) begin
            rsum_sat = rsum_x[RSUM_W] ? {1'b1, {(RSUM_W-1){1'b0}}}
                                      : {1'b0, {(RSUM_W-1){1'b1}}};
        end else begin
            rsum_sat = rsum_x[RSUM_W-1:0];
        end
    end

    always_comb begin
        total   = {r_phi, {MAG_LO_W{1'b0}}} + {{(66-MAG_LO_W-IA_W){1'b0}}, r_plo};
        rounded = r_neg ? (total + 66'd255) : total;
        q       = rounded[65:8];
        if (r_neg) begin
            q_sat = (q > FV_NEG_LIM) ? FV_NEG_LIM : q;
            fv    = ~q_sat[FV_W-1:0] + FV_W'(1);
        end else begin
            q_sat = (q > FV_POS_LIM) ? FV_POS_LIM : q;
            fv    = q_sat[FV_W-1:0];
        end
    end

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_p;
        mem_wdata = '0;
        case (i_cmd.op)
            OP_CLR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr_addr;
            end
            OP_AWR: begin
                mem_we    = r_atom_ok;
                mem_waddr = r_idx[BIN_W-1:0];
                mem_wdata = bsum_sat;
            end
            OP_RACC: begin
                mem_we = 1'b1;
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
        mem_raddr = (i_cmd.op == OP_ARD) ? r_idx[BIN_W-1:0] : r_p;
    end

    assign o_sts.clr_done = (r_clr_addr == BIN_W'(MAX_BINS - 1));

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= mem[mem_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_z_min    <= RST_Z_MIN;
            r_z_max    <= RST_Z_MAX;
            r_ibw      <= RST_INV_BIN_WIDTH;
            r_num_bins <= RST_NUM_BINS;
            r_ia       <= RST_INV_AREA;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_Z_MIN:         r_z_min    <= i_cfg_data[ZLIM_W-1:0];
                CFG_Z_MAX:         r_z_max    <= i_cfg_data[ZLIM_W-1:0];
                CFG_INV_BIN_WIDTH: r_ibw      <= i_cfg_data[IBW_W-1:0];
                CFG_NUM_BINS:      r_num_bins <= i_cfg_data[NB_W-1:0];
                CFG_INV_AREA:      r_ia       <= i_cfg_data[IA_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
            r_rptr     <= '0;
            r_run      <= '0;
            r_valid    <= 1'b0;
        end else begin
            r_valid <= (i_cmd.op == OP_ROUT);
            case (i_cmd.op)
                OP_CLR: begin
                    r_clr_addr <= r_clr_addr + BIN_W'(1);
                end
                OP_RLOAD: begin
                    if (rptr_wrap) begin
                        r_run <= '0;
                    end
                end
                OP_RACC: begin
                    r_run  <= last ? '0 : rsum_sat;
                    r_rptr <= last ? '0 : (r_p + BIN_W'(1));
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_LOAD: begin
                r_in_range <= (i_z_pos > r_z_min) && (i_z_pos < r_z_max);
                r_diff     <= i_z_pos - r_z_min;
                r_q        <= i_charge;
            end
            OP_RLOAD: begin
                r_p <= rptr_wrap ? '0 : r_rptr;
            end
            OP_AMUL: begin
                r_idx <= idx_prod[ZPOS_W+IBW_W-1:IBW_W];
            end
            OP_ARD: begin
                r_atom_ok <= r_in_range
                          && (r_idx < {{(ZPOS_W-NB_W){1'b0}}, n_eff});
            end
            OP_RACC: begin
                r_sum  <= rsum_sat;
                r_last <= last;
            end
            OP_RNEG: begin
                r_neg <= !r_sum[RSUM_W-1] && (r_sum != '0);
                r_mag <= r_sum[RSUM_W-1] ? (~r_sum + RSUM_W'(1)) : r_sum;
            end
            OP_RMLO: begin
                r_plo <= r_mag[MAG_LO_W-1:0] * r_ia;
            end
            OP_RMHI: begin
                r_phi <= r_mag[RSUM_W-1:MAG_LO_W] * r_ia;
            end
            OP_ROUT: begin
                r_out_idx  <= r_p;
                r_out_fv   <= fv;
                r_out_last <= r_last;
            end
            default: begin
            end
        endcase
    end

    assign o_valid       = r_valid;
    assign o_bin_index   = r_out_idx;
    assign o_field_value = r_out_fv;
    assign o_last_bin    = r_out_last;

    a_valid_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> $past(i_cmd.op == OP_ROUT))
        else $error("result beat without output step");

    a_valid_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |=> !r_valid)
        else $error("result strobe longer than one cycle");

endmodule

// ===== rtl/charge_slab_profile_integrator_top.sv =====
// Top level of the charge slab profile integrator: controller plus datapath.
// Depends on csp_pkg, csp_ctrl and csp_dpath.
//
//  channel  | handshake            | payload
//  ---------+----------------------+----------------------------------------
//  command  | i_start / o_busy     | i_func, i_z_pos, i_charge
//  result   | o_valid (strobe)     | o_bin_index, o_field_value, o_last_bin
//  config   | i_cfg_we             | i_cfg_index, i_cfg_data
//
// An atom beat keeps o_busy high through the bin index multiply and the bin memory
// read-modify-write; a new atom is taken only after o_busy falls.
// A readout beat keeps o_busy high through the memory read, running sum, sign step and
// a two-step 42x24 multiply up to the output step; the result strobe comes in the same
// cycle that o_busy falls.
// After reset o_busy stays high while the bin memory is cleared.
// Results are shown for one cycle and cannot be stalled.
module charge_slab_profile_integrator_top import csp_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    output logic                    o_busy,
    input  logic                    i_func,
    input  logic [ZPOS_W-1:0]       i_z_pos,
    input  logic signed [CHG_W-1:0] i_charge,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [CFG_DATA_W-1:0]   i_cfg_data,
    output logic                    o_valid,
    output logic [BIN_W-1:0]        o_bin_index,
    output logic signed [FV_W-1:0]  o_field_value,
    output logic                    o_last_bin
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    csp_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_func  (i_func),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_busy  (o_busy)
    );

    csp_dpath u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_z_pos       (i_z_pos),
        .i_charge      (i_charge),
        .o_valid       (o_valid),
        .o_bin_index   (o_bin_index),
        .o_field_value (o_field_value),
        .o_last_bin    (o_last_bin)
    );

endmodule

// ===== tb/charge_slab_profile_integrator_top_test.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for charge_slab_profile_integrator_top: directed limit and
// pointer cases, heavily loaded bins and randomized frames, checked by a built-in predictor.
// Depends on csp_pkg and the integrator RTL.
module charge_slab_profile_integrator_top_test;
    import csp_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 1000000;
    localparam int unsigned RANDOM_ITEMS = 1350;
    localparam int unsigned BULK_ATOMS   = 100;
    localparam int unsigned CFG_SLOTS    = 1 << CFG_IDX_W;

    localparam logic FUNC_ATOM = 1'b0;
    localparam logic FUNC_READ = 1'b1;

    localparam logic signed [CHG_W-1:0] CHG_MAX = {1'b0, {(CHG_W-1){1'b1}}};
    localparam logic signed [CHG_W-1:0] CHG_MIN = {1'b1, {(CHG_W-1){1'b0}}};

    localparam longint BSUM_MAX = 64'sd2147483647;
    localparam longint BSUM_MIN = -64'sd2147483648;
    localparam longint RSUM_MAX = 64'sd2199023255551;
    localparam longint RSUM_MIN = -64'sd2199023255552;
    localparam longint FV_MAX   = 64'sd140737488355327;
    localparam longint FV_MIN   = -64'sd140737488355328;

    typedef struct {
        logic [BIN_W-1:0]       slab;
        logic signed [FV_W-1:0] field;
        logic                   is_last;
    } slab_result_t;

    logic                    i_clk       = 1'b0;
    logic                    i_rst_n     = 1'b0;
    logic                    i_start     = 1'b0;
    logic                    i_func      = 1'b0;
    logic [ZPOS_W-1:0]       i_z_pos     = '0;
    logic signed [CHG_W-1:0] i_charge    = '0;
    logic                    i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]    i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]   i_cfg_data  = '0;
    logic                    o_busy;
    logic                    o_valid;
    logic [BIN_W-1:0]        o_bin_index;
    logic signed [FV_W-1:0]  o_field_value;
    logic                    o_last_bin;

    charge_slab_profile_integrator_top DUT (.*);

    // predictor state
    logic [ZLIM_W-1:0]        z_lo;
    logic [ZLIM_W-1:0]        z_hi;
    logic [IBW_W-1:0]         slab_scale;
    logic [NB_W-1:0]          slab_count;
    logic [IA_W-1:0]          area_scale;
    logic signed [BSUM_W-1:0] slab_charge [MAX_BINS];
    int unsigned              next_slab;
    longint                   cum_charge;
    slab_result_t             profile_q [$];

    logic [CFG_DATA_W-1:0]    cfg_next [CFG_SLOTS];
    bit                       idle_on;
    int unsigned              n_atoms, n_readouts, n_results, n_writes, n_errors;
    int unsigned              random_items, random_phases, cycle_count;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic int unsigned slabs_in_use();
        if (slab_count == 0) return 1;
        if (slab_count > MAX_BINS) return MAX_BINS;
        return slab_count;
    endfunction

    function automatic void deposit_atom(input logic [ZPOS_W-1:0] z,
                                         input logic signed [CHG_W-1:0] q);
        logic [63:0] idx;
        longint      s;
        if (z <= z_lo || z >= z_hi) return;
        idx = (64'(z - z_lo) * 64'(slab_scale)) >> 32;
        if (idx >= slabs_in_use()) return;
        s = longint'(slab_charge[idx[BIN_W-1:0]]) + longint'(q);
        if (s > BSUM_MAX) s = BSUM_MAX;
        if (s < BSUM_MIN) s = BSUM_MIN;
        slab_charge[idx[BIN_W-1:0]] = s[BSUM_W-1:0];
    endfunction

    function automatic slab_result_t read_slab();
        int unsigned         n, p;
        longint              s;
        logic signed [127:0] prod, ia_wide;
        slab_result_t        r;
        n = slabs_in_use();
        p = next_slab;
        if (p >= n) begin
            p = 0;
            cum_charge = 0;
        end
        s = cum_charge + longint'(slab_charge[p]);
        if (s > RSUM_MAX) s = RSUM_MAX;
        if (s < RSUM_MIN) s = RSUM_MIN;
        cum_charge = s;
        slab_charge[p] = '0;
        prod = -s;
        ia_wide = {104'd0, area_scale};
        prod = (prod * ia_wide) >>> 8;
        if (prod > FV_MAX) prod = FV_MAX;
        else if (prod < FV_MIN) prod = FV_MIN;
        r.slab = BIN_W'(p);
        r.field = prod[FV_W-1:0];
        r.is_last = (p == n - 1);
        if (r.is_last) begin
            next_slab = 0;
            cum_charge = 0;
        end else begin
            next_slab = p + 1;
        end
        return r;
    endfunction

    // predict on each accepted beat, check each result strobe
    always @(posedge i_clk) begin
        slab_result_t want;
        if (!i_rst_n) begin
            z_lo = RST_Z_MIN;
            z_hi = RST_Z_MAX;
            slab_scale = RST_INV_BIN_WIDTH;
            slab_count = RST_NUM_BINS;
            area_scale = RST_INV_AREA;
            foreach (slab_charge[k]) slab_charge[k] = '0;
            next_slab = 0;
            cum_charge = 0;
        end else begin
            if (i_cfg_we) begin
                n_writes++;
                case (i_cfg_index)
                    CFG_Z_MIN:         z_lo = i_cfg_data[ZLIM_W-1:0];
                    CFG_Z_MAX:         z_hi = i_cfg_data[ZLIM_W-1:0];
                    CFG_INV_BIN_WIDTH: slab_scale = i_cfg_data[IBW_W-1:0];
                    CFG_NUM_BINS:      slab_count = i_cfg_data[NB_W-1:0];
                    CFG_INV_AREA:      area_scale = i_cfg_data[IA_W-1:0];
                    default: ;
                endcase
            end
            if (i_start && !o_busy) begin
                if (i_func == FUNC_READ) begin
                    n_readouts++;
                    profile_q.push_back(read_slab());
                end else begin
                    n_atoms++;
                    deposit_atom(i_z_pos, i_charge);
                end
            end
            if (o_valid) begin
                if (profile_q.size() == 0) begin
                    n_errors++;
                    if (n_errors <= 10)
                        $display("unexpected result: bin %0d field %0d last %0b",
                                 o_bin_index, o_field_value, o_last_bin);
                end else begin
                    want = profile_q.pop_front();
                    n_results++;
                    if (o_bin_index !== want.slab || o_field_value !== want.field ||
                        o_last_bin !== want.is_last) begin
                        n_errors++;
                        if (n_errors <= 10)
                            $display({"mismatch: expected bin %0d field %0d last %0b,",
                                      " got bin %0d field %0d last %0b"},
                                     want.slab, want.field, want.is_last,
                                     o_bin_index, o_field_value, o_last_bin);
                    end
                end
            end
        end
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles", cycle_count);
        $display("charge_slab_profile_integrator_top_test: errors");
        $finish;
    end

    task automatic send_beat(input logic func, input logic [ZPOS_W-1:0] z,
                             input logic signed [CHG_W-1:0] q);
        int unsigned gap;
        gap = 0;
        if (idle_on && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 19);
        if (gap > 0) begin
            i_start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_start  <= 1'b1;
        i_func   <= func;
        i_z_pos  <= z;
        i_charge <= q;
        do @(posedge i_clk); while (o_busy);
    endtask

    // drain results, then let the atom pipeline settle
    task automatic wait_idle();
        i_start <= 1'b0;
        do @(posedge i_clk); while (profile_q.size() != 0);
        repeat (10) @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
    endtask

    task automatic write_regs(input int first, input int last_idx);
        for (int k = first; k <= last_idx; k++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_index <= CFG_IDX_W'(k);
            i_cfg_data  <= cfg_next[k];
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [ZPOS_W-1:0] pick_z();
        if (z_hi > z_lo + 1 && $urandom_range(0, 99) < 85)
            return ZPOS_W'(z_lo + 1 + $urandom_range(0, z_hi - z_lo - 2));
        return ZPOS_W'($urandom);
    endfunction

    function automatic logic signed [CHG_W-1:0] pick_charge();
        case ($urandom_range(0, 9))
            0: return CHG_MAX;
            1: return CHG_MIN;
            default: return CHG_W'($urandom);
        endcase
    endfunction

    task automatic test_reset_window();
        idle_on = 0;
        wait_idle();
        send_beat(FUNC_ATOM, RST_Z_MIN, CHG_MAX);
        send_beat(FUNC_ATOM, ZPOS_W'(RST_Z_MIN + 1), CHG_MAX);
        send_beat(FUNC_ATOM, ZPOS_W'(RST_Z_MIN + 1), CHG_MIN);
        send_beat(FUNC_ATOM, ZPOS_W'(RST_Z_MIN + 1), CHG_MIN);
        send_beat(FUNC_ATOM, ZPOS_W'(RST_Z_MIN + 656), 21'sd12345);
        send_beat(FUNC_ATOM, ZPOS_W'(RST_Z_MAX - 1), CHG_MAX);
        send_beat(FUNC_ATOM, RST_Z_MAX, CHG_MAX);
        send_beat(FUNC_ATOM, '0, CHG_MIN);
        send_beat(FUNC_ATOM, '1, CHG_MAX);
        repeat (3) send_beat(FUNC_READ, '1, CHG_MIN);
    endtask

    task automatic test_pointer_and_limits();
        wait_idle();
        // shrink below the read pointer: readout restarts at bin 0
        cfg_next[CFG_NUM_BINS] = 2;
        write_regs(CFG_Z_MIN, CFG_INV_AREA);
        repeat (2) send_beat(FUNC_READ, '0, '0);
        wait_idle();
        cfg_next[CFG_NUM_BINS] = 0;
        write_regs(CFG_Z_MIN, CFG_INV_AREA);
        send_beat(FUNC_ATOM, ZPOS_W'(RST_Z_MIN + 1), CHG_MAX);
        send_beat(FUNC_ATOM, ZPOS_W'(RST_Z_MIN + 700), CHG_MAX);
        send_beat(FUNC_READ, '0, '0);
        wait_idle();
        cfg_next[CFG_NUM_BINS] = '1;
        cfg_next[CFG_INV_BIN_WIDTH] = '1;
        write_regs(CFG_Z_MIN, CFG_INV_AREA);
        send_beat(FUNC_ATOM, ZPOS_W'(RST_Z_MIN + 1), CHG_MAX);
        send_beat(FUNC_ATOM, ZPOS_W'(RST_Z_MIN + 5), CHG_MIN);
        send_beat(FUNC_ATOM, ZPOS_W'(RST_Z_MAX - 1), CHG_MAX);
        repeat (2) send_beat(FUNC_READ, '0, '0);
        wait_idle();
        cfg_next[CFG_INV_BIN_WIDTH] = '0;
        cfg_next[CFG_Z_MAX] = RST_Z_MIN;
        write_regs(CFG_Z_MIN, CFG_INV_AREA);
        send_beat(FUNC_ATOM, ZPOS_W'(RST_Z_MIN + 1), CHG_MAX);
        wait_idle();
        cfg_next[CFG_Z_MAX] = RST_Z_MIN - 1000;
        for (int k = CFG_INV_AREA + 1; k < CFG_SLOTS; k++) cfg_next[k] = $urandom;
        write_regs(CFG_Z_MIN, CFG_SLOTS - 1);
        send_beat(FUNC_ATOM, ZPOS_W'(RST_Z_MIN - 500), CHG_MAX);
        wait_idle();
        cfg_next[CFG_Z_MAX] = RST_Z_MAX;
        write_regs(CFG_Z_MIN, CFG_INV_AREA);
        send_beat(FUNC_ATOM, ZPOS_W'(RST_Z_MAX - 1), 21'sd77);
        send_beat(FUNC_READ, '0, '0);
    endtask

    task automatic test_heavy_bins();
        idle_on = 0;
        wait_idle();
        cfg_next[CFG_Z_MIN] = '0;
        cfg_next[CFG_Z_MAX] = 24'hFFFFFF;
        cfg_next[CFG_INV_BIN_WIDTH] = 32'h10000;
        cfg_next[CFG_NUM_BINS] = 1;
        cfg_next[CFG_INV_AREA] = 24'hFFFFFF;
        write_regs(CFG_Z_MIN, CFG_INV_AREA);
        send_beat(FUNC_READ, '0, '0);
        wait_idle();
        cfg_next[CFG_NUM_BINS] = 2;
        write_regs(CFG_Z_MIN, CFG_INV_AREA);
        repeat (2) send_beat(FUNC_READ, '0, '0);
        // load bin 0 heavily, then spill one atom into bin 1
        repeat (BULK_ATOMS)
            send_beat(FUNC_ATOM, ZPOS_W'($urandom_range(1, 16'hFFFF)), CHG_MAX);
        send_beat(FUNC_ATOM, ZPOS_W'(24'h10000 + $urandom_range(0, 16'hFFFF)), CHG_MAX);
        repeat (2) send_beat(FUNC_READ, '0, '0);
        repeat (BULK_ATOMS)
            send_beat(FUNC_ATOM, ZPOS_W'($urandom_range(1, 16'hFFFF)), CHG_MIN);
        send_beat(FUNC_ATOM, ZPOS_W'(24'h10000 + $urandom_range(0, 16'hFFFF)), CHG_MIN);
        repeat (2) send_beat(FUNC_READ, '0, '0);
    endtask

    task automatic test_random_frames();
        int unsigned     lo, span, nb, ia, frames, atoms, reads;
        longint unsigned ibw_calc;
        while (random_items < RANDOM_ITEMS) begin
            wait_idle();
            idle_on = (random_items < RANDOM_ITEMS * 4 / 5) && ($urandom_range(0, 2) != 0);
            nb = (random_phases == 3) ? MAX_BINS : $urandom_range(1, 24);
            case ($urandom_range(0, 3))
                0: lo = 0;
                1: lo = $urandom_range(24'hFFFF00, 24'hFFFFFD);
                default: lo = $urandom_range(0, 24'hC00000);
            endcase
            span = (random_phases % 4 == 1) ? 24'hFFFFFF - lo
                                            : $urandom_range(2, 24'hFFFFFF - lo);
            ibw_calc = ((64'(nb) << 32) / span) * $urandom_range(90, 115) / 100;
            if (ibw_calc > 64'hFFFFFFFF || $urandom_range(0, 15) == 0)
                ibw_calc = 64'hFFFFFFFF;
            case ($urandom_range(0, 5))
                0: ia = 0;
                1: ia = 24'hFFFFFF;
                default: ia = $urandom_range(0, 24'hFFFFFF);
            endcase
            cfg_next[CFG_Z_MIN] = {8'($urandom), 24'(lo)};
            cfg_next[CFG_Z_MAX] = {8'($urandom), 24'(lo + span)};
            cfg_next[CFG_INV_BIN_WIDTH] = ibw_calc[31:0];
            cfg_next[CFG_NUM_BINS] = {21'($urandom), 11'(nb)};
            cfg_next[CFG_INV_AREA] = {8'($urandom), 24'(ia)};
            write_regs(CFG_Z_MIN, CFG_INV_AREA);
            random_phases++;
            frames = (nb == MAX_BINS) ? 1 : $urandom_range(2, 5);
            repeat (frames) begin
                atoms = (nb == MAX_BINS) ? 80 : $urandom_range(0, 40);
                repeat (atoms) begin
                    send_beat(FUNC_ATOM, pick_z(), pick_charge());
                    random_items++;
                end
                reads = nb + (($urandom_range(0, 4) == 0) ? $urandom_range(1, 2) : 0);
                repeat (reads) begin
                    if ($urandom_range(0, 9) == 0) begin
                        send_beat(FUNC_ATOM, pick_z(), pick_charge());
                        random_items++;
                    end
                    send_beat(FUNC_READ, ZPOS_W'($urandom), CHG_W'($urandom));
                    random_items++;
                end
            end
        end
    endtask

    initial begin
        foreach (cfg_next[k]) cfg_next[k] = '0;
        cfg_next[CFG_Z_MIN] = RST_Z_MIN;
        cfg_next[CFG_Z_MAX] = RST_Z_MAX;
        cfg_next[CFG_INV_BIN_WIDTH] = RST_INV_BIN_WIDTH;
        cfg_next[CFG_NUM_BINS] = RST_NUM_BINS;
        cfg_next[CFG_INV_AREA] = RST_INV_AREA;
        idle_on = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_window();
        test_pointer_and_limits();
        test_heavy_bins();
        test_random_frames();
        wait_idle();
        $display("covered %0d atom beats and %0d readout beats, %0d slab results checked",
                 n_atoms, n_readouts, n_results);
        $display("%0d register writes over %0d random phases, %0d failures",
                 n_writes, random_phases, n_errors);
        if (n_errors == 0) begin
            $display("charge_slab_profile_integrator_top_test: clean");
        end else begin
            $display("charge_slab_profile_integrator_top_test: errors");
        end
        $finish;
    end

endmodule
